### rtl/lkvc_pkg.sv
// Shared constants and types for the LRU key/value cache.
package lkvc_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 4;
    localparam int EFF_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int DATA_W  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef struct packed {
        logic capture;
        logic compare;
        logic apply;
    } dp_cmd_t;

endpackage

### rtl/lkvc_ctrl.sv
// Sequencing state machine for the LRU key/value cache.
module lkvc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output lkvc_pkg::dp_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_APPLY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd.capture = (state_reg == ST_IDLE) && in_valid;
        cmd.compare = (state_reg == ST_MATCH);
        cmd.apply   = (state_reg == ST_APPLY) && (!out_valid_reg || !out_stall);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // A result is produced only after an item has gone through the compare cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |-> $past(state_reg == ST_MATCH) || $past(state_reg == ST_APPLY))
        else $error("apply without a preceding compare");
`endif

endmodule

### rtl/lkvc_dp.sv
// Entry storage, associative compare and recency update for the LRU key/value cache.
module lkvc_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lkvc_pkg::dp_cmd_t                 cmd,
    input  logic                              cfg_we,
    input  logic        [lkvc_pkg::CAP_W-1:0] cfg_wdata,
    input  logic                              action,
    input  logic signed [lkvc_pkg::DATA_W-1:0] lookup_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] write_value,
    output logic                              hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] read_value
);

    logic [lkvc_pkg::DATA_W-1:0] key_mem   [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::DATA_W-1:0] value_mem [lkvc_pkg::ENTRIES];

    logic [lkvc_pkg::ENTRIES-1:0] valid_reg;
    logic [lkvc_pkg::ENTRIES-1:0] valid_next;
    logic [lkvc_pkg::RANK_W-1:0]  rank_reg  [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::RANK_W-1:0]  rank_next [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::OCC_W-1:0]   occ_reg;
    logic [lkvc_pkg::OCC_W-1:0]   occ_next;
    logic [lkvc_pkg::CAP_W-1:0]   cap_reg;

    logic                         act_reg;
    logic [lkvc_pkg::DATA_W-1:0]  key_reg;
    logic [lkvc_pkg::DATA_W-1:0]  wval_reg;
    logic [lkvc_pkg::ENTRIES-1:0] match_vec_reg;

    logic                         hit_reg;
    logic [lkvc_pkg::DATA_W-1:0]  read_value_reg;

    logic                         any_hit;
    logic [lkvc_pkg::IDX_W-1:0]   found_idx;
    logic [lkvc_pkg::RANK_W-1:0]  hit_rank;
    logic [lkvc_pkg::EFF_W-1:0]   eff_cap;
    logic [lkvc_pkg::RANK_W-1:0]  oldest_rank;
    logic                         evict;
    logic [lkvc_pkg::ENTRIES-1:0] victim_vec;
    logic [lkvc_pkg::ENTRIES-1:0] free_vec;
    logic [lkvc_pkg::IDX_W-1:0]   slot_idx;
    logic                         slot_ok;
    logic                         do_fill;
    logic                         do_touch;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = lkvc_pkg::EFF_W'(1);
        end
        else if (lkvc_pkg::EFF_W'(cap_reg) > lkvc_pkg::EFF_W'(lkvc_pkg::ENTRIES))
        begin
            eff_cap = lkvc_pkg::EFF_W'(lkvc_pkg::ENTRIES);
        end
        else
        begin
            eff_cap = lkvc_pkg::EFF_W'(cap_reg);
        end
    end

    always_comb
    begin
        any_hit   = |match_vec_reg;
        found_idx = '0;
        for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec_reg[i])
            begin
                found_idx = lkvc_pkg::IDX_W'(i);
            end
        end
        hit_rank = rank_reg[found_idx];

        // Valid ranks are distinct and dense, so the oldest entry holds occupancy minus one.
        oldest_rank = lkvc_pkg::RANK_W'(occ_reg - lkvc_pkg::OCC_W'(1));
        evict = !any_hit && (act_reg == lkvc_pkg::ACT_PUT)
              && (lkvc_pkg::EFF_W'(occ_reg) >= eff_cap);
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
        begin
            victim_vec[i] = evict && valid_reg[i] && (rank_reg[i] == oldest_rank);
        end
        free_vec = ~valid_reg | victim_vec;
        slot_ok  = |free_vec;
        slot_idx = '0;
        for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                slot_idx = lkvc_pkg::IDX_W'(i);
            end
        end

        do_touch = any_hit;
        do_fill  = !any_hit && (act_reg == lkvc_pkg::ACT_PUT) && slot_ok;

        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end

        if (do_touch)
        begin
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            begin
                if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = lkvc_pkg::RANK_W'(rank_reg[i] + 1'b1);
                end
            end
            rank_next[found_idx] = '0;
        end
        else if (do_fill)
        begin
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            begin
                if (victim_vec[i])
                begin
                    valid_next[i] = 1'b0;
                    rank_next[i]  = '0;
                end
                else if (valid_reg[i])
                begin
                    rank_next[i] = lkvc_pkg::RANK_W'(rank_reg[i] + 1'b1);
                end
            end
            valid_next[slot_idx] = 1'b1;
            rank_next[slot_idx]  = '0;
            if (!evict)
            begin
                occ_next = lkvc_pkg::OCC_W'(occ_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            cap_reg   <= lkvc_pkg::CAP_RESET;
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (cmd.apply)
            begin
                valid_reg <= valid_next;
                occ_reg   <= occ_next;
                for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
                begin
                    rank_reg[i] <= rank_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= action;
            key_reg  <= lookup_key;
            wval_reg <= write_value;
        end
        if (cmd.compare)
        begin
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            begin
                match_vec_reg[i] <= valid_reg[i] && (key_mem[i] == key_reg);
            end
        end
        if (cmd.apply)
        begin
            hit_reg <= any_hit;
            if (any_hit && (act_reg == lkvc_pkg::ACT_GET))
            begin
                read_value_reg <= value_mem[found_idx];
            end
            else
            begin
                read_value_reg <= '0;
            end
            if (any_hit && (act_reg == lkvc_pkg::ACT_PUT))
            begin
                value_mem[found_idx] <= wval_reg;
            end
            else if (do_fill)
            begin
                key_mem[slot_idx]   <= key_reg;
                value_mem[slot_idx] <= wval_reg;
            end
        end
    end

    assign hit        = hit_reg;
    assign read_value = read_value_reg;

`ifndef SYNTHESIS
    // Occupancy tracks the number of valid entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy does not match valid entries");

    // Keys are unique, so at most one entry can match.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |-> $onehot0(match_vec_reg))
        else $error("more than one entry matched the key");

    // An eviction happens only together with a fill, so occupancy never drops.
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg >= $past(occ_reg))
        else $error("occupancy decreased");
`endif

endmodule

### rtl/lru_key_value_cache_unit.sv
// Top level of the LRU key/value cache.
//
// A fully associative store of lkvc_pkg::ENTRIES key/value pairs with
// least-recently-used replacement. An input item carries action (0 get,
// 1 put), lookup_key and write_value; it is accepted when in_valid is high
// and in_stall is low. Each item gives exactly one result item: hit, and
// read_value (the stored value on a get hit, zero otherwise), offered on
// out_valid and taken when out_stall is low.
// An item goes through capture, the parallel key compare across all
// entries, and the update of recency ranks and storage, in that order.
// The result appears in the cycle after the update. The block works on
// one item at a time; in_stall is high from acceptance until the update
// is done. A waiting result does not block acceptance of the next item,
// but the update stage holds while out_stall keeps an earlier result in
// the output register. Reset clears all entries, empties the store and
// sets capacity_limit to 8. cfg_we writes capacity_limit from cfg_wdata;
// the user must write it only while the block is idle, which the block
// itself does not enforce.
module lru_key_value_cache_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic        [lkvc_pkg::CAP_W-1:0]  cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               action,
    input  logic signed [lkvc_pkg::DATA_W-1:0] lookup_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] write_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] read_value
);

    lkvc_pkg::dp_cmd_t cmd;

    lkvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    lkvc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .action      (action),
        .lookup_key  (lookup_key),
        .write_value (write_value),
        .hit         (hit),
        .read_value  (read_value)
    );

endmodule
